// File: sv/wav_sample_decode_mono_mix_macros.svh
// Assertion macros shared by the mono downmix RTL.
`ifndef WAV_SAMPLE_DECODE_MONO_MIX_MACROS_SVH
`define WAV_SAMPLE_DECODE_MONO_MIX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSDM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsdm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsdm assertion failed");

`endif

// File: sv/wsdm_pkg.sv
// Shared types and constants for the mono downmix block.
`timescale 1ns / 1ps

package wsdm_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FORMAT_CODE   = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_BITS   = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] FORMAT_CODE_RST   = 16'd1;
    localparam logic [6:0]  SAMPLE_BITS_RST   = 7'd16;
    localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd1;

    // Format codes.
    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    // Sample depths.
    localparam logic [6:0] BITS_8  = 7'd8;
    localparam logic [6:0] BITS_16 = 7'd16;
    localparam logic [6:0] BITS_24 = 7'd24;
    localparam logic [6:0] BITS_32 = 7'd32;
    localparam logic [6:0] BITS_64 = 7'd64;

    localparam logic signed [31:0] Q31_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

    // Decoded channel value.
    typedef struct packed {
        logic               error;
        logic signed [31:0] value;
    } dec_t;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: sv/wav_sample_decode_mono_mix.sv
// A sample is accepted in S_IDLE and decoded in S_ACC; a channel that does not end a
// frame is added to the frame sum and the block returns to S_IDLE. A frame-ending channel goes
// through S_DIV, where the bit-serial divider gives one quotient bit per cycle, and then S_PUT
// loads the output register; an unsupported format goes from S_ACC straight to S_PUT with the
// error flag set. One item at a time, and S_PUT waits while a full output register is stalled.
// Reset (rst_n, asynchronous, active low) restores the format registers and clears the frame state.
`timescale 1ns / 1ps

`include "wav_sample_decode_mono_mix_macros.svh"

module wav_sample_decode_mono_mix
#(
    parameter int MAX_CHANNELS = wsdm_pkg::MAX_CHANNELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [63:0]        raw_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] mono_sample,
    output logic               format_error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SUM_W = 32 + $clog2(MAX_CHANNELS);
    localparam logic [3:0] CNT_CAP = 4'((MAX_CHANNELS < 15) ? MAX_CHANNELS : 15);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ACC  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [15:0]             format_code_reg;
    logic [6:0]              sample_bits_reg;
    logic [3:0]              channel_count_reg;
    logic [63:0]             raw_reg;
    logic [IDX_W-1:0]        channel_index_reg;
    logic [IDX_W-1:0]        channel_index_next;
    logic signed [SUM_W-1:0] frame_sum_reg;
    logic signed [SUM_W-1:0] frame_sum_next;
    logic signed [SUM_W-1:0] sum_added;
    logic signed [31:0]      res_reg;
    logic signed [31:0]      res_next;
    logic                    res_err_reg;
    logic                    res_err_next;
    logic                    out_valid_reg;
    logic signed [31:0]      mono_reg;
    logic                    err_reg;
    logic [3:0]              count_eff;
    logic                    frame_end;
    logic                    div_start;
    logic                    out_load;
    logic signed [31:0]      div_result;
    wsdm_pkg::dec_t          dec;
    wsdm_pkg::div_status_t   div_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_code_reg   <= wsdm_pkg::FORMAT_CODE_RST;
            sample_bits_reg   <= wsdm_pkg::SAMPLE_BITS_RST;
            channel_count_reg <= wsdm_pkg::CHANNEL_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wsdm_pkg::CFG_FORMAT_CODE:   format_code_reg   <= cfg_data;
                wsdm_pkg::CFG_SAMPLE_BITS:   sample_bits_reg   <= cfg_data[6:0];
                wsdm_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[3:0];
                default:                     ;
            endcase
        end
    end

    wsdm_decode u_decode
    (
        .raw         (raw_reg),
        .format_code (format_code_reg),
        .sample_bits (sample_bits_reg),
        .dec         (dec)
    );

    always_comb
    begin
        if (channel_count_reg == 4'd0)
        begin
            count_eff = 4'd1;
        end
        else if (channel_count_reg > CNT_CAP)
        begin
            count_eff = CNT_CAP;
        end
        else
        begin
            count_eff = channel_count_reg;
        end
    end

    assign sum_added = frame_sum_reg + SUM_W'(dec.value);
    assign frame_end = ((8'(channel_index_reg) + 8'd1) >= 8'(count_eff));
    assign div_start = (state_reg == S_ACC) && !dec.error && frame_end;
    assign out_load  = (state_reg == S_PUT) && (!out_valid_reg || !out_stall);

    wsdm_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_added),
        .divisor  (count_eff),
        .status   (div_stat),
        .result   (div_result)
    );

    always_comb
    begin
        state_next         = state_reg;
        channel_index_next = channel_index_reg;
        frame_sum_next     = frame_sum_reg;
        res_next           = res_reg;
        res_err_next       = res_err_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (dec.error)
                begin
                    channel_index_next = '0;
                    frame_sum_next     = '0;
                    res_next           = '0;
                    res_err_next       = 1'b1;
                    state_next         = S_PUT;
                end
                else if (frame_end)
                begin
                    channel_index_next = '0;
                    frame_sum_next     = '0;
                    state_next         = S_DIV;
                end
                else
                begin
                    channel_index_next = channel_index_reg + 1'b1;
                    frame_sum_next     = sum_added;
                    state_next         = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    res_next     = div_result;
                    res_err_next = 1'b0;
                    state_next   = S_PUT;
                end
            end
            S_PUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            channel_index_reg <= '0;
            frame_sum_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            channel_index_reg <= channel_index_next;
            frame_sum_reg     <= frame_sum_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            raw_reg <= raw_sample;
        end
        res_reg     <= res_next;
        res_err_reg <= res_err_next;
        if (out_load)
        begin
            mono_reg <= res_reg;
            err_reg  <= res_err_reg;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign mono_sample  = mono_reg;
    assign format_error = err_reg;

    `WSDM_ASSERT_IMP(a_err_result_zero, clk, rst_n, out_valid && format_error, mono_sample == 32'sd0)
    `WSDM_ASSERT_IMP(a_index_bound, clk, rst_n, 1'b1, 32'(channel_index_reg) < MAX_CHANNELS)
    `WSDM_ASSERT_IMP(a_out_from_put, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_PUT)
    `WSDM_ASSERT_IMP(a_div_in_div_state, clk, rst_n, div_stat.busy, state_reg == S_DIV)

endmodule

// File: sv/wsdm_decode.sv
// Sample decoder: PCM and IEEE float formats to a signed Q1.31 value.
`timescale 1ns / 1ps

module wsdm_decode
(
    input  logic [63:0]   raw,
    input  logic [15:0]   format_code,
    input  logic [6:0]    sample_bits,
    output wsdm_pkg::dec_t dec
);

    logic        is_f64;
    logic        neg;
    logic        not_finite;
    logic        sat;
    logic [10:0] exp_eff;
    logic [10:0] rsh;
    logic [52:0] mant;
    logic [52:0] shifted;
    logic [30:0] mag;
    logic signed [31:0] fval;

    // Both float widths share one right shifter. The single-precision mantissa
    // is aligned to the double-precision position, which keeps every shift a
    // right shift of at least 22 places.
    always_comb
    begin
        is_f64 = (sample_bits == wsdm_pkg::BITS_64);
        if (is_f64)
        begin
            neg        = raw[63];
            not_finite = (raw[62:52] == 11'h7FF);
            sat        = (raw[62:52] >= 11'd1023);
            exp_eff    = (raw[62:52] == 11'd0) ? 11'd1 : raw[62:52];
            mant       = {(raw[62:52] != 11'd0), raw[51:0]};
            rsh        = 11'd1044 - exp_eff;
        end
        else
        begin
            neg        = raw[31];
            not_finite = (raw[30:23] == 8'hFF);
            sat        = (raw[30:23] >= 8'd127);
            exp_eff    = (raw[30:23] == 8'd0) ? 11'd1 : {3'd0, raw[30:23]};
            mant       = {(raw[30:23] != 8'd0), raw[22:0], 29'd0};
            rsh        = 11'd148 - exp_eff;
        end

        if (rsh >= 11'd53)
        begin
            shifted = '0;
        end
        else
        begin
            shifted = mant >> rsh[5:0];
        end
        mag = shifted[30:0];

        if (not_finite)
        begin
            fval = '0;
        end
        else if (sat)
        begin
            fval = neg ? wsdm_pkg::Q31_MIN : wsdm_pkg::Q31_MAX;
        end
        else if (neg)
        begin
            fval = -$signed({1'b0, mag});
        end
        else
        begin
            fval = $signed({1'b0, mag});
        end
    end

    always_comb
    begin
        dec = '0;
        case (format_code)
            wsdm_pkg::FMT_PCM:
            begin
                case (sample_bits)
                    wsdm_pkg::BITS_8:  dec.value = $signed({~raw[7], raw[6:0], 24'd0});
                    wsdm_pkg::BITS_16: dec.value = $signed({raw[15:0], 16'd0});
                    wsdm_pkg::BITS_24: dec.value = $signed({raw[23:0], 8'd0});
                    wsdm_pkg::BITS_32: dec.value = $signed(raw[31:0]);
                    default:           dec.error = 1'b1;
                endcase
            end
            wsdm_pkg::FMT_FLOAT:
            begin
                if (sample_bits inside {wsdm_pkg::BITS_32, wsdm_pkg::BITS_64})
                begin
                    dec.value = fval;
                end
                else
                begin
                    dec.error = 1'b1;
                end
            end
            default:
            begin
                dec.error = 1'b1;
            end
        endcase
    end

endmodule

// File: sv/wsdm_div.sv
// Bit-serial restoring divider: signed frame sum by channel count, saturated to Q1.31.
`timescale 1ns / 1ps

`include "wav_sample_decode_mono_mix_macros.svh"

module wsdm_div
#(
    parameter int SUM_W = 35
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  dividend,
    input  logic [3:0]               divisor,
    output wsdm_pkg::div_status_t    status,
    output logic signed [31:0]       result
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic             neg_reg;
    logic             neg_next;
    logic [3:0]       divisor_reg;
    logic [3:0]       divisor_next;
    logic [3:0]       rem_reg;
    logic [3:0]       rem_next;
    logic [SUM_W-1:0] quo_reg;
    logic [SUM_W-1:0] quo_next;
    logic [4:0]       trial;
    logic             fits;

    // One quotient bit per cycle: shift the next dividend bit into the
    // remainder and subtract the divisor when it fits.
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        neg_next     = neg_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        if (start)
        begin
            cnt_next     = CNT_W'(SUM_W);
            neg_next     = dividend[SUM_W-1];
            divisor_next = divisor;
            rem_next     = '0;
            quo_next     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            rem_next  = fits ? 4'(trial - {1'b0, divisor_reg}) : trial[3:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > SUM_W'(64'h8000_0000))
            begin
                result = wsdm_pkg::Q31_MIN;
            end
            else
            begin
                result = $signed(32'(-quo_reg));
            end
        end
        else if (quo_reg > SUM_W'(64'h7FFF_FFFF))
        begin
            result = wsdm_pkg::Q31_MAX;
        end
        else
        begin
            result = $signed(quo_reg[31:0]);
        end
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

    `WSDM_ASSERT_IMP(a_start_when_free, clk, rst_n, start, cnt_reg == '0)
    `WSDM_ASSERT_IMP(a_done_follows_busy, clk, rst_n, done_reg, $past(cnt_reg) == CNT_W'(1))
    `WSDM_ASSERT_IMP(a_rem_below_divisor, clk, rst_n, cnt_reg != '0, rem_reg < divisor_reg)

endmodule
